### design/assert_macros.svh
// Assertion macros shared by the RTL; NO_ASSERTIONS compiles them out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ESC_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("%m: check failed");
`define ESC_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("%m: check failed");
`else
`define ESC_ASSERT(lbl, prop)
`define ESC_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

### design/esc_pkg.sv
`default_nettype none
package esc_pkg;

	localparam int QUEUE_DEPTH = 4;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 64;
	localparam int DIV_BITS = 64;
	localparam int DIV_CNT_W = 7;

	localparam logic [2:0] MUL_WB = 3'd4;

	localparam logic [31:0] C_T_ROUND = 32'd128;
	localparam logic [63:0] C_P_OFFSET = 64'd128000;
	localparam logic [63:0] C_P_BASE = 64'd1048576;
	localparam logic [63:0] C_P_SCALE = 64'd3125;
	localparam logic [31:0] C_H_OFFSET = 32'd76800;
	localparam logic [31:0] C_H_CLAMP = 32'd419430400;
	localparam logic [31:0] C_H_ROUND_L = 32'd16384;
	localparam logic [31:0] C_H_INNER = 32'd2097152;
	localparam logic [31:0] C_H_ROUND_R = 32'd8192;
	localparam logic [31:0] C_H_BIAS = 32'd32768;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_TEMPERATURE   = 3'd0,
		CFG_PRESSURE_LOW  = 3'd1,
		CFG_PRESSURE_HIGH = 3'd2,
		CFG_MIXED         = 3'd3,
		CFG_HUMIDITY      = 3'd4
	} cfg_reg_t;

	typedef struct packed {
		logic [19:0] raw_t;
		logic [19:0] raw_p;
		logic [15:0] raw_h;
	} item_t;

	typedef struct packed {
		logic [15:0] t1;
		logic [15:0] t2;
		logic [15:0] t3;
		logic [15:0] p1;
		logic [15:0] p2;
		logic [15:0] p3;
		logic [15:0] p4;
		logic [15:0] p5;
		logic [15:0] p6;
		logic [15:0] p7;
		logic [15:0] p8;
		logic [15:0] p9;
		logic [7:0]  h1;
		logic [15:0] h2;
		logic [7:0]  h3;
		logic [11:0] h4;
		logic [11:0] h5;
		logic [7:0]  h6;
	} cal_t;

	typedef enum logic [4:0] {
		ST_IDLE, ST_T0, ST_T1, ST_T2,
		ST_P0, ST_P1, ST_P2, ST_P3, ST_P4, ST_P5, ST_P6,
		ST_DIVW, ST_P7, ST_P8, ST_P9,
		ST_H0, ST_H1, ST_H2, ST_H3, ST_H4, ST_H5, ST_H6, ST_H7
	} state_t;

endpackage
`default_nettype wire

### design/esc_front.sv
`default_nettype none
module esc_front (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           in_valid,
	output logic                                in_stall,
	input  wire logic [19:0]                    raw_temperature,
	input  wire logic [19:0]                    raw_pressure,
	input  wire logic [15:0]                    raw_humidity,
	input  wire logic                           cfg_we,
	input  wire logic [esc_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [esc_pkg::CFG_DATA_W-1:0] cfg_data,
	input  wire logic                           q_full,
	output logic                                q_push,
	output esc_pkg::item_t                      q_item,
	output esc_pkg::cal_t                       cal
);

	logic           valid_s1;
	esc_pkg::item_t item_s1;
	logic           load;
	logic [47:0]    cal_t_q;
	logic [63:0]    cal_pl_q;
	logic [63:0]    cal_ph_q;
	logic [47:0]    cal_m_q;
	logic [31:0]    cal_h_q;

	assign q_push   = valid_s1 && !q_full;
	assign load     = !valid_s1 || q_push;
	assign in_stall = !load;
	assign q_item   = item_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (load) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (load && in_valid) begin
			item_s1 <= '{raw_t: raw_temperature, raw_p: raw_pressure, raw_h: raw_humidity};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cal_t_q  <= '0;
			cal_pl_q <= '0;
			cal_ph_q <= '0;
			cal_m_q  <= '0;
			cal_h_q  <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				esc_pkg::CFG_TEMPERATURE:   cal_t_q  <= cfg_data[47:0];
				esc_pkg::CFG_PRESSURE_LOW:  cal_pl_q <= cfg_data;
				esc_pkg::CFG_PRESSURE_HIGH: cal_ph_q <= cfg_data;
				esc_pkg::CFG_MIXED:         cal_m_q  <= cfg_data[47:0];
				esc_pkg::CFG_HUMIDITY:      cal_h_q  <= cfg_data[31:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		cal.t1 = cal_t_q[15:0];
		cal.t2 = cal_t_q[31:16];
		cal.t3 = cal_t_q[47:32];
		cal.p1 = cal_pl_q[15:0];
		cal.p2 = cal_pl_q[31:16];
		cal.p3 = cal_pl_q[47:32];
		cal.p4 = cal_pl_q[63:48];
		cal.p5 = cal_ph_q[15:0];
		cal.p6 = cal_ph_q[31:16];
		cal.p7 = cal_ph_q[47:32];
		cal.p8 = cal_ph_q[63:48];
		cal.p9 = cal_m_q[15:0];
		cal.h1 = cal_m_q[23:16];
		cal.h2 = cal_m_q[39:24];
		cal.h3 = cal_m_q[47:40];
		cal.h4 = cal_h_q[11:0];
		cal.h5 = cal_h_q[23:12];
		cal.h6 = cal_h_q[31:24];
	end

endmodule
`default_nettype wire

### design/esc_fifo.sv
`default_nettype none
module esc_fifo #(
	parameter int DEPTH = esc_pkg::QUEUE_DEPTH
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           push,
	input  wire esc_pkg::item_t push_item,
	output logic                full,
	input  wire logic           pop,
	output esc_pkg::item_t      pop_item,
	output logic                empty
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	esc_pkg::item_t   mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full     = count_q == CNT_W'(DEPTH);
	assign empty    = count_q == '0;
	assign pop_item = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

`include "assert_macros.svh"
	`ESC_ASSERT(a_no_overflow, push |-> !full)
	`ESC_ASSERT(a_no_underflow, pop |-> !empty)

endmodule
`default_nettype wire

### design/esc_div.sv
`default_nettype none
module esc_div (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	input  wire logic [63:0] dividend,
	input  wire logic [63:0] divisor,
	output logic             done,
	output logic [63:0]      quotient
);

	logic                          busy_q;
	logic                          done_q;
	logic [esc_pkg::DIV_CNT_W-1:0] cnt_q;
	logic [63:0]                   rem_q;
	logic [63:0]                   quo_q;
	logic [63:0]                   ud_q;
	logic                          neg_q;
	logic [64:0]                   rem_sh;
	logic [64:0]                   diff;
	logic                          ge;

	assign rem_sh   = {rem_q, quo_q[63]};
	assign diff     = rem_sh - {1'b0, ud_q};
	assign ge       = !diff[64];
	assign done     = done_q;
	assign quotient = neg_q ? 64'd0 - quo_q : quo_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= esc_pkg::DIV_CNT_W'(esc_pkg::DIV_BITS);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == esc_pkg::DIV_CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			neg_q <= dividend[63] ^ divisor[63];
			quo_q <= dividend[63] ? 64'd0 - dividend : dividend;
			ud_q  <= divisor[63] ? 64'd0 - divisor : divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			rem_q <= ge ? diff[63:0] : rem_sh[63:0];
			quo_q <= {quo_q[62:0], ge};
		end
	end

`include "assert_macros.svh"
	`ESC_ASSERT(a_start_idle, start |-> !busy_q)

endmodule
`default_nettype wire

### design/esc_back.sv
`default_nettype none
module esc_back (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         q_empty,
	input  wire esc_pkg::item_t q_item,
	output logic              q_pop,
	input  wire esc_pkg::cal_t cal,
	output logic              out_valid,
	input  wire logic         out_stall,
	output logic signed [31:0] temperature_centi,
	output logic [31:0]       pressure_q24_8,
	output logic              pressure_invalid,
	output logic [16:0]       humidity_q22_10
);

	esc_pkg::state_t state_q, state_d;
	logic [2:0]  phase_q;
	logic        at_wb;
	logic        mul_state;
	logic        out_free;
	logic        out_load;
	logic        div_start;
	logic        div_done;
	logic [63:0] div_q;
	logic [63:0] op_a, op_b;
	logic [63:0] prod_q, acc_q;
	logic [63:0] m;

	logic [19:0] raw_t_q, raw_p_q;
	logic [15:0] raw_h_q;
	logic [31:0] ta_q, xx_q, temp_q, hv_q;
	logic [63:0] v1_q, sq_q, v2_q, pt_q, p_q;
	logic [31:0] pres_q;
	logic        inv_q;
	logic [31:0] left_q, a6_q, a3_q, inner_q, right_q, hh_q, hq_q;

	logic        out_valid_q;
	logic signed [31:0] o_temp_q;
	logic [31:0] o_pres_q;
	logic        o_inv_q;
	logic [16:0] o_hum_q;

	logic [31:0] t2_32, t3_32, h2_32, h4_32, h5_32, h6_32;
	logic [63:0] p2_64, p3_64, p4_64, p5_64, p6_64, p7_64, p8_64, p9_64;
	logic [31:0] tf_n, tf5, temp_n, hv_w, hv_c, vs;
	logic [63:0] p_sum;

	assign t2_32 = {{16{cal.t2[15]}}, cal.t2};
	assign t3_32 = {{16{cal.t3[15]}}, cal.t3};
	assign h2_32 = {{16{cal.h2[15]}}, cal.h2};
	assign h4_32 = {{20{cal.h4[11]}}, cal.h4};
	assign h5_32 = {{20{cal.h5[11]}}, cal.h5};
	assign h6_32 = {{24{cal.h6[7]}}, cal.h6};
	assign p2_64 = {{48{cal.p2[15]}}, cal.p2};
	assign p3_64 = {{48{cal.p3[15]}}, cal.p3};
	assign p4_64 = {{48{cal.p4[15]}}, cal.p4};
	assign p5_64 = {{48{cal.p5[15]}}, cal.p5};
	assign p6_64 = {{48{cal.p6[15]}}, cal.p6};
	assign p7_64 = {{48{cal.p7[15]}}, cal.p7};
	assign p8_64 = {{48{cal.p8[15]}}, cal.p8};
	assign p9_64 = {{48{cal.p9[15]}}, cal.p9};

	assign m        = acc_q;
	assign at_wb    = phase_q == esc_pkg::MUL_WB;
	assign out_free = !out_valid_q || !out_stall;

	assign tf_n   = ta_q + 32'($signed(m[31:0]) >>> 14);
	assign tf5    = tf_n + {tf_n[29:0], 2'b00} + esc_pkg::C_T_ROUND;
	assign temp_n = 32'($signed(tf5) >>> 8);
	assign vs     = 32'($signed(hh_q) >>> 15);
	assign hv_w   = hh_q - 32'($signed(m[31:0]) >>> 4);
	assign hv_c   = hv_w[31] ? 32'd0 : (hv_w > esc_pkg::C_H_CLAMP ? esc_pkg::C_H_CLAMP : hv_w);
	assign p_sum  = 64'($signed(p_q + pt_q + 64'($signed(m) >>> 19)) >>> 8) + (p7_64 << 4);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			esc_pkg::ST_IDLE: if (!q_empty) state_d = esc_pkg::ST_T0;
			esc_pkg::ST_T0:   if (at_wb) state_d = esc_pkg::ST_T1;
			esc_pkg::ST_T1:   if (at_wb) state_d = esc_pkg::ST_T2;
			esc_pkg::ST_T2:   if (at_wb) state_d = esc_pkg::ST_P0;
			esc_pkg::ST_P0:   if (at_wb) state_d = esc_pkg::ST_P1;
			esc_pkg::ST_P1:   if (at_wb) state_d = esc_pkg::ST_P2;
			esc_pkg::ST_P2:   if (at_wb) state_d = esc_pkg::ST_P3;
			esc_pkg::ST_P3:   if (at_wb) state_d = esc_pkg::ST_P4;
			esc_pkg::ST_P4:   if (at_wb) state_d = esc_pkg::ST_P5;
			esc_pkg::ST_P5:   if (at_wb) state_d = esc_pkg::ST_P6;
			esc_pkg::ST_P6: begin
				if (at_wb) state_d = (v1_q == '0) ? esc_pkg::ST_H0 : esc_pkg::ST_DIVW;
			end
			esc_pkg::ST_DIVW: if (div_done) state_d = esc_pkg::ST_P7;
			esc_pkg::ST_P7:   if (at_wb) state_d = esc_pkg::ST_P8;
			esc_pkg::ST_P8:   if (at_wb) state_d = esc_pkg::ST_P9;
			esc_pkg::ST_P9:   if (at_wb) state_d = esc_pkg::ST_H0;
			esc_pkg::ST_H0:   if (at_wb) state_d = esc_pkg::ST_H1;
			esc_pkg::ST_H1:   if (at_wb) state_d = esc_pkg::ST_H2;
			esc_pkg::ST_H2:   if (at_wb) state_d = esc_pkg::ST_H3;
			esc_pkg::ST_H3:   if (at_wb) state_d = esc_pkg::ST_H4;
			esc_pkg::ST_H4:   if (at_wb) state_d = esc_pkg::ST_H5;
			esc_pkg::ST_H5:   if (at_wb) state_d = esc_pkg::ST_H6;
			esc_pkg::ST_H6:   if (at_wb) state_d = esc_pkg::ST_H7;
			esc_pkg::ST_H7:   if (at_wb && out_free) state_d = esc_pkg::ST_IDLE;
			default:          state_d = esc_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		q_pop     = (state_q == esc_pkg::ST_IDLE) && !q_empty;
		mul_state = (state_q != esc_pkg::ST_IDLE) && (state_q != esc_pkg::ST_DIVW);
		div_start = (state_q == esc_pkg::ST_P6) && at_wb && (v1_q != '0);
		out_load  = (state_q == esc_pkg::ST_H7) && at_wb && out_free;
		op_a = '0;
		op_b = '0;
		unique case (state_q)
			esc_pkg::ST_T0: begin
				op_a = {32'd0, {15'd0, raw_t_q[19:3]} - {15'd0, cal.t1, 1'b0}};
				op_b = {32'd0, t2_32};
			end
			esc_pkg::ST_T1: begin
				op_a = {32'd0, {16'd0, raw_t_q[19:4]} - {16'd0, cal.t1}};
				op_b = op_a;
			end
			esc_pkg::ST_T2: begin
				op_a = {32'd0, xx_q};
				op_b = {32'd0, t3_32};
			end
			esc_pkg::ST_P0: begin
				op_a = v1_q;
				op_b = v1_q;
			end
			esc_pkg::ST_P1: begin
				op_a = sq_q;
				op_b = p6_64;
			end
			esc_pkg::ST_P2: begin
				op_a = v1_q;
				op_b = p5_64;
			end
			esc_pkg::ST_P3: begin
				op_a = sq_q;
				op_b = p3_64;
			end
			esc_pkg::ST_P4: begin
				op_a = v1_q;
				op_b = p2_64;
			end
			esc_pkg::ST_P5: begin
				op_a = (64'd1 << 47) + v1_q;
				op_b = {48'd0, cal.p1};
			end
			esc_pkg::ST_P6: begin
				op_a = ((esc_pkg::C_P_BASE - {44'd0, raw_p_q}) << 31) - v2_q;
				op_b = esc_pkg::C_P_SCALE;
			end
			esc_pkg::ST_P7: begin
				op_a = p9_64;
				op_b = pt_q;
			end
			esc_pkg::ST_P8: begin
				op_a = sq_q;
				op_b = pt_q;
			end
			esc_pkg::ST_P9: begin
				op_a = p8_64;
				op_b = p_q;
			end
			esc_pkg::ST_H0: begin
				op_a = {32'd0, h5_32};
				op_b = {32'd0, hv_q};
			end
			esc_pkg::ST_H1: begin
				op_a = {32'd0, hv_q};
				op_b = {32'd0, h6_32};
			end
			esc_pkg::ST_H2: begin
				op_a = {32'd0, hv_q};
				op_b = {56'd0, cal.h3};
			end
			esc_pkg::ST_H3: begin
				op_a = {32'd0, a6_q};
				op_b = {32'd0, a3_q};
			end
			esc_pkg::ST_H4: begin
				op_a = {32'd0, inner_q};
				op_b = {32'd0, h2_32};
			end
			esc_pkg::ST_H5: begin
				op_a = {32'd0, left_q};
				op_b = {32'd0, right_q};
			end
			esc_pkg::ST_H6: begin
				op_a = {32'd0, vs};
				op_b = {32'd0, vs};
			end
			esc_pkg::ST_H7: begin
				op_a = {32'd0, hq_q};
				op_b = {56'd0, cal.h1};
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= esc_pkg::ST_IDLE;
			phase_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (mul_state) begin
				if (!at_wb) begin
					phase_q <= phase_q + 1'b1;
				end else if (state_d != state_q) begin
					phase_q <= '0;
				end
			end
			if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (mul_state) begin
			case (phase_q)
				3'd0: prod_q <= op_a[31:0] * op_b[31:0];
				3'd1: begin
					acc_q  <= prod_q;
					prod_q <= op_a[31:0] * op_b[63:32];
				end
				3'd2: begin
					acc_q[63:32] <= acc_q[63:32] + prod_q[31:0];
					prod_q       <= op_a[63:32] * op_b[31:0];
				end
				3'd3: acc_q[63:32] <= acc_q[63:32] + prod_q[31:0];
				default: ;
			endcase
		end

		if (q_pop) begin
			raw_t_q <= q_item.raw_t;
			raw_p_q <= q_item.raw_p;
			raw_h_q <= q_item.raw_h;
		end

		if (div_done) begin
			p_q  <= div_q;
			pt_q <= 64'($signed(div_q) >>> 13);
		end

		if (at_wb) begin
			case (state_q)
				esc_pkg::ST_T0: ta_q <= 32'($signed(m[31:0]) >>> 11);
				esc_pkg::ST_T1: xx_q <= 32'($signed(m[31:0]) >>> 12);
				esc_pkg::ST_T2: begin
					temp_q <= temp_n;
					v1_q   <= {{32{tf_n[31]}}, tf_n} - esc_pkg::C_P_OFFSET;
					hv_q   <= tf_n - esc_pkg::C_H_OFFSET;
				end
				esc_pkg::ST_P0: sq_q <= m;
				esc_pkg::ST_P1: v2_q <= m;
				esc_pkg::ST_P2: v2_q <= v2_q + (m << 17) + (p4_64 << 35);
				esc_pkg::ST_P3: pt_q <= 64'($signed(m) >>> 8);
				esc_pkg::ST_P4: v1_q <= pt_q + (m << 12);
				esc_pkg::ST_P5: v1_q <= 64'($signed(m) >>> 33);
				esc_pkg::ST_P6: begin
					inv_q  <= v1_q == '0;
					pres_q <= '0;
				end
				esc_pkg::ST_P7: sq_q <= m;
				esc_pkg::ST_P8: pt_q <= 64'($signed(m) >>> 25);
				esc_pkg::ST_P9: pres_q <= p_sum[31:0];
				esc_pkg::ST_H0: begin
					left_q <= 32'($signed({2'b00, raw_h_q, 14'd0} - (h4_32 << 20) - m[31:0]
						+ esc_pkg::C_H_ROUND_L) >>> 15);
				end
				esc_pkg::ST_H1: a6_q <= 32'($signed(m[31:0]) >>> 10);
				esc_pkg::ST_H2: a3_q <= 32'($signed(m[31:0]) >>> 11) + esc_pkg::C_H_BIAS;
				esc_pkg::ST_H3: inner_q <= 32'($signed(m[31:0]) >>> 10) + esc_pkg::C_H_INNER;
				esc_pkg::ST_H4: begin
					right_q <= 32'($signed(m[31:0] + esc_pkg::C_H_ROUND_R) >>> 14);
				end
				esc_pkg::ST_H5: hh_q <= m[31:0];
				esc_pkg::ST_H6: hq_q <= 32'($signed(m[31:0]) >>> 7);
				default: ;
			endcase
		end

		if (out_load) begin
			o_temp_q <= temp_q;
			o_pres_q <= pres_q;
			o_inv_q  <= inv_q;
			o_hum_q  <= hv_c[28:12];
		end
	end

	esc_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (m),
		.divisor  (v1_q),
		.done     (div_done),
		.quotient (div_q)
	);

	assign out_valid         = out_valid_q;
	assign temperature_centi = o_temp_q;
	assign pressure_q24_8    = o_pres_q;
	assign pressure_invalid  = o_inv_q;
	assign humidity_q22_10   = o_hum_q;

`include "assert_macros.svh"
	`ESC_ASSERT_NEXT(a_div_wait, div_start, state_q == esc_pkg::ST_DIVW)
	`ESC_ASSERT(a_div_done_state, div_done |-> state_q == esc_pkg::ST_DIVW)
	`ESC_ASSERT(a_out_no_clobber, out_load |-> !(out_valid_q && out_stall))

endmodule
`default_nettype wire

### design/env_sensor_compensation.sv
// Environmental sensor compensation.
// Input channel: in_valid / in_stall carry one raw temperature, pressure and
// humidity triple per transaction. Output channel: out_valid / out_stall carry
// the compensated temperature, pressure, invalid flag and humidity.
// Calibration words are written through cfg_we / cfg_index / cfg_data; the
// user must write them only while the block is idle, which the block itself
// does not enforce; indexes past the last register are dropped.
// A front stage registers each transaction into a queue of QUEUE_DEPTH
// entries; the back end works one item at a time with one shared 32x32
// multiplier (up to 21 products) and a radix-2 divider (64 iterations). When
// the pressure divisor is zero the division and the last pressure products
// are skipped. The back end takes a new item only once it is back in idle.
// While out_stall is high the result holds and the back end keeps working on
// the next item, then waits at its final step; the queue absorbs new input
// until full, then in_stall rises.
// Reset clears all calibration registers to zero and empties the queue.
`default_nettype none
module env_sensor_compensation #(
	parameter int QUEUE_DEPTH = esc_pkg::QUEUE_DEPTH
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           in_valid,
	output logic                                in_stall,
	input  wire logic [19:0]                    raw_temperature,
	input  wire logic [19:0]                    raw_pressure,
	input  wire logic [15:0]                    raw_humidity,
	output logic                                out_valid,
	input  wire logic                           out_stall,
	output logic signed [31:0]                  temperature_centi,
	output logic [31:0]                         pressure_q24_8,
	output logic                                pressure_invalid,
	output logic [16:0]                         humidity_q22_10,
	input  wire logic                           cfg_we,
	input  wire logic [esc_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [esc_pkg::CFG_DATA_W-1:0] cfg_data
);

	logic           q_full, q_push, q_pop, q_empty;
	esc_pkg::item_t q_in, q_out;
	esc_pkg::cal_t  cal;

	esc_front u_front (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.raw_temperature (raw_temperature),
		.raw_pressure    (raw_pressure),
		.raw_humidity    (raw_humidity),
		.cfg_we          (cfg_we),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.q_full          (q_full),
		.q_push          (q_push),
		.q_item          (q_in),
		.cal             (cal)
	);

	esc_fifo #(.DEPTH(QUEUE_DEPTH)) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_item (q_in),
		.full      (q_full),
		.pop       (q_pop),
		.pop_item  (q_out),
		.empty     (q_empty)
	);

	esc_back u_back (
		.clk               (clk),
		.arst_n            (arst_n),
		.q_empty           (q_empty),
		.q_item            (q_out),
		.q_pop             (q_pop),
		.cal               (cal),
		.out_valid         (out_valid),
		.out_stall         (out_stall),
		.temperature_centi (temperature_centi),
		.pressure_q24_8    (pressure_q24_8),
		.pressure_invalid  (pressure_invalid),
		.humidity_q22_10   (humidity_q22_10)
	);

endmodule
`default_nettype wire
